// File: sv/ghalloc_pkg.sv
// Shared types and constants for the generational handle allocator.
`timescale 1ns / 1ps
`default_nettype none

package ghalloc_pkg;

    localparam int KIND_W    = 2;
    localparam int IDX_W     = 16;
    localparam int GEN_W     = 32;
    localparam int OUT_IDX_W = 8;

    localparam logic [KIND_W-1:0] KIND_CREATE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_DESTROY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CHECK   = 2'd2;

    // generation table entry: live flag plus live or pending generation
    typedef struct packed {
        logic             live;
        logic [GEN_W-1:0] gen;
    } t_gen_entry;

    localparam int ENTRY_W = GEN_W + 1;

    // second stage control word
    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
        logic              inrange;
        logic              pop_ok;
        logic              unw;
    } t_s2_ctl;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
    } t_push;

    typedef struct packed {
        logic             ok;
        logic [GEN_W-1:0] gen;
    } t_result;

endpackage

`default_nettype wire

// File: sv/ghalloc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module ghalloc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

`default_nettype wire

// File: sv/ghalloc_stack.sv
// LIFO free-index stack with cached top, prefetched second entry and fill mark.
`timescale 1ns / 1ps
`default_nettype none

module ghalloc_stack #(
    parameter int ENTITIES = 256
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_en,
    input  wire logic                            i_pop_req,
    input  wire ghalloc_pkg::t_push              i_push,
    output logic                                 o_pop_ok,
    output logic [$clog2(ENTITIES)-1:0]          o_slot,
    output logic [$clog2(ENTITIES+1)-1:0]        o_low
);

    localparam int AW = $clog2(ENTITIES);
    localparam int CW = $clog2(ENTITIES + 1);
    localparam int UW = CW + 1;
    localparam logic [AW-1:0] LAST = AW'(ENTITIES - 1);

    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_low, n_low;
    logic [AW-1:0] r_top, n_top;
    logic [AW-1:0] r_sec_pos;
    logic          r_sec_init;
    logic [AW-1:0] ram_q;
    logic [AW-1:0] sec_val;
    logic [AW-1:0] push_idx;
    logic [AW-1:0] rd_addr;
    logic          push;
    logic          pop;
    logic          avail;
    logic          wr_en;

    assign push_idx = i_push.idx[AW-1:0];
    assign push     = i_push.valid && (r_count < CW'(ENTITIES));
    assign avail    = (r_count != '0) || push;
    assign o_pop_ok = i_pop_req && avail;
    assign pop      = i_en && o_pop_ok;
    assign o_slot   = push ? push_idx : r_top;
    assign o_low    = r_low;
    assign wr_en    = i_en && push;

    // never-written positions still hold their reset value
    assign sec_val  = r_sec_init ? (LAST - r_sec_pos) : ram_q;

    always_comb begin
        n_count = r_count;
        n_top   = r_top;
        case ({wr_en, pop})
            2'b10: begin
                n_count = r_count + CW'(1);
                n_top   = push_idx;
            end
            2'b01: begin
                n_count = r_count - CW'(1);
                n_top   = sec_val;
            end
            default: begin
            end
        endcase
        n_low = (n_count < r_low) ? n_count : r_low;
    end

    assign rd_addr = AW'(n_count - CW'(2));

    ghalloc_ram #(
        .WIDTH (AW),
        .DEPTH (ENTITIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (push_idx),
        .i_re    (i_en),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= CW'(ENTITIES);
            r_low      <= CW'(ENTITIES);
            r_top      <= '0;
            r_sec_pos  <= AW'(ENTITIES - 2);
            r_sec_init <= 1'b1;
        end else if (i_en) begin
            r_count    <= n_count;
            r_low      <= n_low;
            r_top      <= n_top;
            r_sec_pos  <= rd_addr;
            r_sec_init <= UW'(n_count) < (UW'(n_low) + UW'(2));
        end
    end

endmodule

`default_nettype wire

// File: sv/ghalloc_gen.sv
// Generation table: lookup, handle validation and update with write forwarding.
`timescale 1ns / 1ps
`default_nettype none

module ghalloc_gen #(
    parameter int ENTITIES = 256
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_en,
    input  wire logic [$clog2(ENTITIES)-1:0]     i_rd_addr,
    input  wire ghalloc_pkg::t_s2_ctl            i_ctl,
    input  wire logic [$clog2(ENTITIES)-1:0]     i_slot,
    input  wire logic [ghalloc_pkg::GEN_W-1:0]   i_hgen,
    output ghalloc_pkg::t_result                 o_res,
    output ghalloc_pkg::t_push                   o_push
);

    localparam int AW = $clog2(ENTITIES);

    logic [ghalloc_pkg::ENTRY_W-1:0] ram_q;
    ghalloc_pkg::t_gen_entry         q_ent;
    ghalloc_pkg::t_gen_entry         eff;
    ghalloc_pkg::t_gen_entry         wdata;
    ghalloc_pkg::t_gen_entry         r_fw_data;
    logic [AW-1:0]                   r_fw_addr;
    logic                            r_fw_valid;
    logic [ghalloc_pkg::GEN_W-1:0]   new_gen;
    logic [ghalloc_pkg::GEN_W-1:0]   inc;
    logic [ghalloc_pkg::GEN_W-1:0]   inc_gen;
    logic                            hit;
    logic                            hvalid;
    logic                            create_ok;
    logic                            destroy_ok;
    logic                            check_ok;
    logic                            we;

    assign q_ent = ghalloc_pkg::t_gen_entry'(ram_q);
    assign hit   = r_fw_valid && (r_fw_addr == i_slot);

    always_comb begin
        if (hit) begin
            eff = r_fw_data;
        end else if (i_ctl.unw) begin
            eff = '0;
        end else begin
            eff = q_ent;
        end
    end

    assign hvalid  = i_ctl.inrange && (i_hgen != '0) && eff.live && (eff.gen == i_hgen);
    assign new_gen = (eff.gen == '0) ? ghalloc_pkg::GEN_W'(1) : eff.gen;
    assign inc     = eff.gen + ghalloc_pkg::GEN_W'(1);
    assign inc_gen = (inc == '0) ? ghalloc_pkg::GEN_W'(1) : inc;

    always_comb begin
        create_ok  = 1'b0;
        destroy_ok = 1'b0;
        check_ok   = 1'b0;
        case (i_ctl.kind)
            ghalloc_pkg::KIND_CREATE:  create_ok  = i_ctl.valid && i_ctl.pop_ok;
            ghalloc_pkg::KIND_DESTROY: destroy_ok = i_ctl.valid && hvalid;
            ghalloc_pkg::KIND_CHECK:   check_ok   = i_ctl.valid && hvalid;
            default: begin
            end
        endcase
    end

    assign we         = i_en && (create_ok || destroy_ok);
    assign wdata.live = create_ok;
    assign wdata.gen  = create_ok ? new_gen : inc_gen;

    assign o_res.ok    = create_ok || destroy_ok || check_ok;
    assign o_res.gen   = create_ok ? new_gen : '0;
    assign o_push.valid = destroy_ok;
    assign o_push.idx   = ghalloc_pkg::IDX_W'(i_slot);

    ghalloc_ram #(
        .WIDTH (ghalloc_pkg::ENTRY_W),
        .DEPTH (ENTITIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (i_slot),
        .i_wdata (wdata),
        .i_re    (i_en),
        .i_raddr (i_rd_addr),
        .o_rdata (ram_q)
    );

    // read issued on the same edge as a write returns old data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw_valid <= 1'b0;
        end else if (i_en) begin
            r_fw_valid <= we;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fw_addr <= i_slot;
            r_fw_data <= wdata;
        end
    end

endmodule

`default_nettype wire

// File: sv/generational_handle_allocator.sv
// Top level of the generational handle allocator.
//
// Input channel: i_in_valid / o_in_stall carry one word of i_kind,
// i_handle_index and i_handle_gen (create, destroy, check).
// Output channel: o_out_valid / i_out_stall carry one result word of
// o_ok, o_out_index and o_out_gen for every accepted word, in order.
// Stages: stage 1, stage 2 and output registers. Throughput: one word
// per cycle while no result stalls. Each cycle does one pop or push on the
// free-stack RAM and one read plus one write on the generation table RAM;
// a write forwarding register covers back-to-back hits on the same slot.
// Reset: synchronous, active low. The free stack holds every index with
// index 0 on top and all generations read as zero. No clearing pass runs:
// a low-water mark on the stack tells which positions and slots were never
// written, so words are taken in the first cycle after reset.
// Stall: while a result waits under i_out_stall the whole pipeline holds
// and o_in_stall is raised; otherwise o_in_stall stays low.
`timescale 1ns / 1ps
`default_nettype none

module generational_handle_allocator #(
    parameter int ENTITIES = 256
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire logic [ghalloc_pkg::KIND_W-1:0]       i_kind,
    input  wire logic [ghalloc_pkg::IDX_W-1:0]        i_handle_index,
    input  wire logic [ghalloc_pkg::GEN_W-1:0]        i_handle_gen,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output logic                                      o_ok,
    output logic [ghalloc_pkg::OUT_IDX_W-1:0]         o_out_index,
    output logic [ghalloc_pkg::GEN_W-1:0]             o_out_gen
);

    localparam int AW = $clog2(ENTITIES);
    localparam int CW = $clog2(ENTITIES + 1);
    localparam int UW = CW + 1;

    logic                               en;

    logic                               r_s1_valid;
    logic [ghalloc_pkg::KIND_W-1:0]     r_s1_kind;
    logic [ghalloc_pkg::IDX_W-1:0]      r_s1_idx;
    logic [ghalloc_pkg::GEN_W-1:0]      r_s1_gen;

    ghalloc_pkg::t_s2_ctl               r_s2_ctl;
    ghalloc_pkg::t_s2_ctl               n_s2_ctl;
    logic [AW-1:0]                      r_s2_slot;
    logic [ghalloc_pkg::GEN_W-1:0]      r_s2_gen;

    logic                               r_o_valid;
    logic                               r_o_ok;
    logic [ghalloc_pkg::OUT_IDX_W-1:0]  r_o_index;
    logic [ghalloc_pkg::GEN_W-1:0]      r_o_gen;

    logic                               pop_req;
    logic                               pop_ok;
    logic [AW-1:0]                      stack_slot;
    logic [CW-1:0]                      low;
    logic [AW-1:0]                      s1_slot;
    ghalloc_pkg::t_push                 push;
    ghalloc_pkg::t_result               res;

    assign en         = !(r_o_valid && i_out_stall);
    assign o_in_stall = !en;

    // stage 1: stack pop and table read address
    assign pop_req = r_s1_valid && (r_s1_kind == ghalloc_pkg::KIND_CREATE);
    assign s1_slot = (r_s1_kind == ghalloc_pkg::KIND_CREATE) ? stack_slot
                                                              : r_s1_idx[AW-1:0];

    assign n_s2_ctl.valid   = r_s1_valid;
    assign n_s2_ctl.kind    = r_s1_kind;
    assign n_s2_ctl.inrange = ({1'b0, r_s1_idx} < (ghalloc_pkg::IDX_W + 1)'(ENTITIES));
    assign n_s2_ctl.pop_ok  = pop_ok;
    assign n_s2_ctl.unw     = (UW'(s1_slot) + UW'(low)) >= UW'(ENTITIES);

    ghalloc_stack #(
        .ENTITIES (ENTITIES)
    ) u_stack (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_pop_req (pop_req),
        .i_push    (push),
        .o_pop_ok  (pop_ok),
        .o_slot    (stack_slot),
        .o_low     (low)
    );

    // stage 2: validate and update generation
    ghalloc_gen #(
        .ENTITIES (ENTITIES)
    ) u_gen (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (en),
        .i_rd_addr (s1_slot),
        .i_ctl     (r_s2_ctl),
        .i_slot    (r_s2_slot),
        .i_hgen    (r_s2_gen),
        .o_res     (res),
        .o_push    (push)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_ctl   <= '0;
            r_o_valid  <= 1'b0;
        end else if (en) begin
            r_s1_valid <= i_in_valid;
            r_s1_kind  <= i_kind;
            r_s1_idx   <= i_handle_index;
            r_s1_gen   <= i_handle_gen;
            r_s2_ctl   <= n_s2_ctl;
            r_s2_slot  <= s1_slot;
            r_s2_gen   <= r_s1_gen;
            r_o_valid  <= r_s2_ctl.valid;
            r_o_ok     <= res.ok;
            r_o_gen    <= res.gen;
            r_o_index  <= (res.ok && (r_s2_ctl.kind == ghalloc_pkg::KIND_CREATE))
                          ? ghalloc_pkg::OUT_IDX_W'(r_s2_slot) : '0;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_ok        = r_o_ok;
    assign o_out_index = r_o_index;
    assign o_out_gen   = r_o_gen;

endmodule

`default_nettype wire

// File: sv/ghalloc_checker.sv
// Port-level assertions for the generational handle allocator, with bind.
`timescale 1ns / 1ps
`default_nettype none

module ghalloc_checker (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             o_in_stall,
    input  wire logic                             o_out_valid,
    input  wire logic                             i_out_stall,
    input  wire logic                             o_ok,
    input  wire logic [ghalloc_pkg::OUT_IDX_W-1:0] o_out_index,
    input  wire logic [ghalloc_pkg::GEN_W-1:0]     o_out_gen
);

    // a waiting result word holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_ok) && $stable(o_out_index) && $stable(o_out_gen)))
        else $error("result word changed while stalled");

    // failed words carry no handle
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_ok) |-> ((o_out_index == '0) && (o_out_gen == '0)))
        else $error("failed result carries a handle");

    // a nonzero index only comes with a nonzero generation
    a_new_handle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_index != '0)) |-> (o_ok && (o_out_gen != '0)))
        else $error("created handle without generation");

    // input side only stalls behind a stalled result
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without output backpressure");

endmodule

bind generational_handle_allocator ghalloc_checker u_ghalloc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_ok        (o_ok),
    .o_out_index (o_out_index),
    .o_out_gen   (o_out_gen)
);

`default_nettype wire
